>>> src/lphm_pkg.sv
`timescale 1ns / 1ps

package lphm_pkg;

	localparam int SLOTS = 1024;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = IDX_W + 1;

	localparam logic [KEY_W-1:0] DEAD_KEY   = '1;
	localparam logic [KEY_W-1:0] EMPTY_KEY  = '0;
	localparam logic [CNT_W-1:0] HALF_SLOTS = CNT_W'(SLOTS / 2);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);

	localparam logic KIND_SET = 1'b0;
	localparam logic KIND_GET = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISSING  = 2'd1,
		ST_FULL     = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

endpackage

>>> src/linear_probe_hash_map.sv
`timescale 1ns / 1ps

// channel  | valid     | stall     | words
// ---------+-----------+-----------+----------------------------
// input    | in_valid  | in_stall  | kind, key, value
// output   | out_valid | out_stall | read_value, status
//
// An operation is accepted in S_IDLE; each probed slot is read from the key store
// (S_READ) and compared (S_CHECK); S_FINISH loads the output register; a reserved
// key goes from S_IDLE straight to S_FINISH. After reset a clearing pass writes
// all 1024 key slots, one per cycle, and in_stall stays high until the pass ends.
// One result waits in the output register while the next word is taken; the
// sequencer holds its result only when that register is still full and stalled.

module linear_probe_hash_map import lphm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VAL_W-1:0] read_value,
	output logic [1:0]       status
);

	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [VAL_W-1:0] val_mem [SLOTS];

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] used_q;
	logic             out_valid_q;

	logic             kind_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] gap_q;
	logic             gap_vld_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [VAL_W-1:0] val_rd_q;
	status_t          res_status_q;
	logic [VAL_W-1:0] res_value_q;
	logic [VAL_W-1:0] read_value_q;
	status_t          status_q;

	logic             accept;
	logic             reserved;
	logic             s_empty, s_hit, s_dead, probe_done;
	logic             finish_go;
	logic             key_we, val_we, rd_en, used_inc;
	logic [IDX_W-1:0] key_wa, val_wa;
	logic [KEY_W-1:0] key_wd;
	status_t          fin_status;
	logic [VAL_W-1:0] fin_value;

	assign reserved   = (key == EMPTY_KEY) || (key == DEAD_KEY);
	assign accept     = (state_q == S_IDLE) && in_valid;
	assign s_empty    = (key_rd_q == EMPTY_KEY);
	assign s_hit      = (key_rd_q == key_q);
	assign s_dead     = (key_rd_q == DEAD_KEY);
	assign probe_done = s_empty || s_hit || (cnt_q == LAST_IDX);
	assign finish_go  = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid)
					state_d = reserved ? S_FINISH : S_READ;
			end
			S_READ:   state_d = S_CHECK;
			S_CHECK: begin
				if (probe_done)
					state_d = S_FINISH;
				else
					state_d = S_READ;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall)
					state_d = S_IDLE;
			end
			default:  state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != S_IDLE);
		rd_en      = (state_q == S_READ);
		key_we     = 1'b0;
		key_wa     = pos_q;
		key_wd     = key_q;
		val_we     = 1'b0;
		val_wa     = pos_q;
		used_inc   = 1'b0;
		fin_status = ST_OK;
		fin_value  = '0;
		case (state_q)
			S_CLEAR: begin
				key_we = 1'b1;
				key_wa = clr_q;
				key_wd = EMPTY_KEY;
			end
			S_CHECK: begin
				if (probe_done) begin
					if (kind_q == KIND_GET) begin
						if (s_hit)
							fin_value = val_rd_q;
						else
							fin_status = ST_MISSING;
					end else if (value_q == '0) begin
						if (s_hit) begin
							key_we = 1'b1;
							key_wd = DEAD_KEY;
						end else begin
							fin_status = ST_MISSING;
						end
					end else if (s_hit) begin
						val_we = 1'b1;
					end else if (used_q >= HALF_SLOTS) begin
						fin_status = ST_FULL;
					end else if (gap_vld_q || s_dead) begin
						key_we = 1'b1;
						val_we = 1'b1;
						key_wa = gap_vld_q ? gap_q : pos_q;
						val_wa = gap_vld_q ? gap_q : pos_q;
					end else if (s_empty) begin
						key_we   = 1'b1;
						val_we   = 1'b1;
						used_inc = 1'b1;
					end else begin
						fin_status = ST_FULL;
					end
				end
			end
			default: begin
				key_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (used_inc)
				used_q <= used_q + 1'b1;
			if (finish_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind;
			key_q        <= key;
			value_q      <= value;
			pos_q        <= key[IDX_W-1:0];
			cnt_q        <= '0;
			gap_vld_q    <= 1'b0;
			res_status_q <= reserved ? ST_RESERVED : ST_OK;
			res_value_q  <= '0;
		end
		if (state_q == S_CHECK) begin
			if (probe_done) begin
				res_status_q <= fin_status;
				res_value_q  <= fin_value;
			end else begin
				pos_q <= pos_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
				if (s_dead && !gap_vld_q) begin
					gap_q     <= pos_q;
					gap_vld_q <= 1'b1;
				end
			end
		end
		if (finish_go) begin
			read_value_q <= res_value_q;
			status_q     <= res_status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_wa] <= key_wd;
		if (rd_en)
			key_rd_q <= key_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (val_we)
			val_mem[val_wa] <= value_q;
		if (rd_en)
			val_rd_q <= val_mem[pos_q];
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

>>> sim/hash_map_check_pkg.sv
`timescale 1ns / 1ps

package hash_map_check_pkg;

	import lphm_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		status_t          status;
	} hash_result_t;

	class hash_map_scoreboard;

		logic [KEY_W-1:0] key_tab [SLOTS];
		logic [VAL_W-1:0] val_tab [SLOTS];
		logic [CNT_W-1:0] used_cnt;
		hash_result_t     expected_q [$];
		int               errors;
		int               checked;

		function new();
			foreach (key_tab[i]) begin
				key_tab[i] = EMPTY_KEY;
				val_tab[i] = '0;
			end
			used_cnt = '0;
			errors   = 0;
			checked  = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// walk from the home slot until the key, an empty slot, or a full lap
		function void find_slot(input logic [KEY_W-1:0] k, output bit found,
				output int hit, output int gap, output int hole);
			int pos;
			bit done;
			pos   = int'(k[IDX_W-1:0]);
			found = 1'b0;
			done  = 1'b0;
			hit   = SLOTS;
			gap   = SLOTS;
			hole  = SLOTS;
			for (int i = 0; i < SLOTS && !done; i++) begin
				if (key_tab[pos] == EMPTY_KEY) begin
					hole = pos;
					done = 1'b1;
				end else if (key_tab[pos] == k) begin
					hit   = pos;
					found = 1'b1;
					done  = 1'b1;
				end else begin
					if (key_tab[pos] == DEAD_KEY && gap == SLOTS)
						gap = pos;
					pos = (pos == SLOTS - 1) ? 0 : pos + 1;
				end
			end
		endfunction

		function void note_word(input logic op, input logic [KEY_W-1:0] k,
				input logic [VAL_W-1:0] v);
			hash_result_t r;
			bit found;
			int hit, gap, hole;
			r.read_value = '0;
			r.status     = ST_OK;
			if (k == EMPTY_KEY || k == DEAD_KEY) begin
				r.status = ST_RESERVED;
			end else begin
				find_slot(k, found, hit, gap, hole);
				if (op == KIND_GET) begin
					if (found)
						r.read_value = val_tab[hit];
					else
						r.status = ST_MISSING;
				end else if (v == '0) begin
					if (found)
						key_tab[hit] = DEAD_KEY;
					else
						r.status = ST_MISSING;
				end else if (found) begin
					val_tab[hit] = v;
				end else if (used_cnt >= HALF_SLOTS) begin
					r.status = ST_FULL;
				end else if (gap < SLOTS) begin
					key_tab[gap] = k;
					val_tab[gap] = v;
				end else if (hole < SLOTS) begin
					key_tab[hole] = k;
					val_tab[hole] = v;
					used_cnt      = used_cnt + 1'b1;
				end else begin
					r.status = ST_FULL;
				end
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(input logic [VAL_W-1:0] rv, input logic [1:0] st);
			hash_result_t e;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result with no word pending: read_value %h, status %0d", rv, st);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (rv !== e.read_value) begin
					$error("read_value mismatch: expected %h, actual %h", e.read_value, rv);
					errors++;
				end
				if (st !== e.status) begin
					$error("status mismatch: expected %0d, actual %0d", e.status, st);
					errors++;
				end
			end
		endfunction

	endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import lphm_pkg::*, hash_map_check_pkg::*;;

	localparam int POOL_N     = 48;
	localparam int IDLE_LIMIT = 20000;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic             kind       = KIND_SET;
	logic [KEY_W-1:0] key        = '0;
	logic [VAL_W-1:0] value      = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [VAL_W-1:0] read_value;
	logic [1:0]       status;

	hash_map_scoreboard sb = new();

	logic [KEY_W-1:0] pool_keys [POOL_N];
	logic [KEY_W-1:0] fill_keys [$];
	bit               sender_steady = 1'b0;
	bit               hold_done     = 1'b0;
	int               idle_cycles   = 0;

	linear_probe_hash_map dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status)
	);

	always #5 clk = ~clk;

	task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		@(negedge clk);
		while (!sender_steady && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		key      <= k;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(op, k, v);
	endtask

	// drop valid and hold until every word has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic pool_op();
		int r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		k = pool_keys[$urandom_range(POOL_N - 1)];
		if (r < 35)
			send_word(KIND_SET, k, ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom());
		else if (r < 45)
			send_word(KIND_SET, k, '0);
		else if (r < 80)
			send_word(KIND_GET, k, $urandom());
		else if (r < 92)
			send_word(logic'($urandom_range(1)), $urandom(), $urandom());
		else
			send_word(logic'($urandom_range(1)),
				$urandom_range(1) ? DEAD_KEY : EMPTY_KEY, $urandom());
	endtask

	task automatic fill_op();
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		if ($urandom_range(3) == 0 && fill_keys.size() != 0) begin
			send_word(KIND_GET, fill_keys[$urandom_range(fill_keys.size() - 1)], $urandom());
		end else begin
			k = $urandom();
			if (k == EMPTY_KEY || k == DEAD_KEY)
				k = 32'h1234_0001;
			v = $urandom();
			if (v == '0)
				v = 32'h0000_0001;
			fill_keys.push_back(k);
			send_word(KIND_SET, k, v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_result(read_value, status);
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!hold_done && sb.checked >= 150) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end else if (sb.checked >= 480 && sb.checked < 660) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 18);
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("linear_probe_hash_map verification failed");
		$finish;
	end

	initial begin
		logic [IDX_W-1:0] home;
		for (int i = 0; i < POOL_N; i++) begin
			home = IDX_W'(1016 + $urandom_range(15));
			pool_keys[i] = {15'($urandom()), 1'b1, 6'(i), home};
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(KIND_GET, 32'h0000_0001, 32'h0000_0000);
		send_word(KIND_SET, EMPTY_KEY, 32'h0000_0005);
		send_word(KIND_GET, DEAD_KEY, 32'h0000_0000);
		send_word(KIND_SET, DEAD_KEY, 32'hFFFF_FFFF);
		send_word(KIND_SET, 32'h0000_0001, 32'hFFFF_FFFF);
		send_word(KIND_GET, 32'h0000_0001, 32'h0000_0000);
		send_word(KIND_SET, 32'h0000_0401, 32'h8000_0000);
		send_word(KIND_SET, 32'h0000_0801, 32'h1234_5678);
		send_word(KIND_SET, 32'h0000_0001, 32'h0000_0001);
		send_word(KIND_SET, 32'h0000_0001, 32'h0000_0000);
		send_word(KIND_SET, 32'h0000_0001, 32'h0000_0000);
		send_word(KIND_SET, 32'h0000_0801, 32'hA5A5_A5A5);
		send_word(KIND_GET, 32'h0000_0801, 32'h0000_0000);
		send_word(KIND_GET, 32'h0000_0001, 32'hFFFF_FFFF);
		send_word(KIND_SET, 32'h0000_0C01, 32'h5A5A_5A5A);
		send_word(KIND_GET, 32'h0000_0C01, 32'h0000_0000);
		send_word(KIND_SET, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_word(KIND_SET, 32'hFFFF_FBFE, 32'h0000_0002);
		send_word(KIND_SET, 32'h7FFF_FFFE, 32'h0000_0003);
		send_word(KIND_SET, 32'h0000_07FE, 32'h0000_0004);
		send_word(KIND_GET, 32'h0000_07FE, 32'h0000_0000);
		send_word(KIND_SET, 32'hFFFF_FBFE, 32'h0000_0000);
		send_word(KIND_GET, 32'h0000_07FE, 32'h0000_0000);
		send_word(KIND_GET, 32'h0000_0003, 32'h0000_0000);
		send_word(KIND_SET, 32'hFFFF_FFFE, 32'h0000_0000);
		drain();

		for (int n = 0; n < 700; n++) begin
			sender_steady = (n >= 450 && n < 650);
			pool_op();
		end
		sender_steady = 1'b0;
		drain();

		for (int n = 0; n < 600; n++)
			fill_op();
		drain();

		for (int n = 0; n < 300; n++) begin
			if ($urandom_range(4) == 0)
				fill_op();
			else
				pool_op();
		end
		drain();

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("linear_probe_hash_map verification clean");
		else
			$display("linear_probe_hash_map verification failed");
		$finish;
	end

endmodule
